[rtl/ifsd_pkg.sv]
`default_nettype none

package ifsd_pkg;

    // Frame geometry.
    localparam int FRAME_BYTES = 380;
    localparam int CHANNELS    = 46;
    localparam int LINE_WIDTH  = 200;

    localparam int DATA_START  = 10;
    localparam int GROUP_PITCH = 92;
    localparam int GROUPS      = 4;
    localparam int DATA_END    = DATA_START + GROUPS * GROUP_PITCH;

    localparam int COUNTER_POS = 4;
    localparam int TIME_POS0   = 12;
    localparam int TIME_POS1   = 13;
    localparam int TIME_POS2   = 14;
    localparam int TIME_POS3   = 15;

    localparam int END_COUNTER = 51;

    // Field widths.
    localparam int POS_W  = $clog2(FRAME_BYTES);
    localparam int GRP_W  = $clog2(GROUPS);
    localparam int WOFF_W = $clog2(GROUP_PITCH);
    localparam int CH_W   = 6;
    localparam int COL_W  = $clog2(LINE_WIDTH);
    localparam int LINE_W = 16;
    localparam int WORD_W = 16;
    localparam int TIME_W = 33;
    localparam int OFS_W  = 32;

    localparam logic [OFS_W-1:0] OFFSET_RESET = 32'd1443521880;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_EOL    = 1'b1;

    // Where the current byte sits within its frame.
    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic              in_data;
        logic [GRP_W-1:0]  grp;
        logic [WOFF_W-1:0] woff;
        logic              last;
    } pos_t;

endpackage

`default_nettype wire

[rtl/ifsd_pos_ctr.sv]
`default_nettype none

// Byte position within the frame, with the pixel group and the offset
// inside the group kept as running counters so no divide is needed.
module ifsd_pos_ctr
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          adv,
    output ifsd_pkg::pos_t     where
);

    logic [ifsd_pkg::POS_W-1:0]  pos_reg,  pos_next;
    logic [ifsd_pkg::GRP_W-1:0]  grp_reg,  grp_next;
    logic [ifsd_pkg::WOFF_W-1:0] woff_reg, woff_next;
    logic                        in_data;
    logic                        last;

    assign in_data = (32'(pos_reg) >= ifsd_pkg::DATA_START) &&
                     (32'(pos_reg) <  ifsd_pkg::DATA_END);
    assign last    = (32'(pos_reg) == ifsd_pkg::FRAME_BYTES - 1);

    always_comb
    begin
        pos_next  = pos_reg;
        grp_next  = grp_reg;
        woff_next = woff_reg;
        if (adv)
        begin
            if (last)
            begin
                pos_next  = '0;
                grp_next  = '0;
                woff_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                if (in_data)
                begin
                    if (32'(woff_reg) == ifsd_pkg::GROUP_PITCH - 1)
                    begin
                        woff_next = '0;
                        grp_next  = grp_reg + 1'b1;
                    end
                    else
                    begin
                        woff_next = woff_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            grp_reg  <= '0;
            woff_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            grp_reg  <= grp_next;
            woff_reg <= woff_next;
        end
    end

    assign where.pos     = pos_reg;
    assign where.in_data = in_data;
    assign where.grp     = grp_reg;
    assign where.woff    = woff_reg;
    assign where.last    = last;

endmodule

`default_nettype wire

[rtl/instrument_frame_sample_demux.sv]
// Timing: a result beat is registered and appears on the output in the cycle after the input beat that causes it.
// Throughput: one byte per cycle; a new byte is taken every cycle unless a finished result
// is held by a stalled output, which is the single output register.
// Reset: asynchronous, active low; alignment restarts at byte 0, the line count and kept
// time clear to zero, and time_offset returns to its default.
`default_nettype none

module instrument_frame_sample_demux
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // Configuration: time_offset register.
    input  wire logic                          cfg_wr_en,
    input  wire logic [ifsd_pkg::OFS_W-1:0]    cfg_wr_data,

    // Byte stream in.
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    data_byte,

    // Result beats out.
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               kind,
    output logic [ifsd_pkg::CH_W-1:0]          channel,
    output logic [ifsd_pkg::COL_W-1:0]         column,
    output logic [ifsd_pkg::LINE_W-1:0]        line_number,
    output logic [ifsd_pkg::WORD_W-1:0]        sample_value,
    output logic [ifsd_pkg::TIME_W-1:0]        timestamp
);

    logic in_take;

    // Position within the current frame.
    ifsd_pkg::pos_t where;

    ifsd_pos_ctr u_pos
    (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (in_take),
        .where (where)
    );

    // Block state.
    logic [ifsd_pkg::OFS_W-1:0]  offset_reg;
    logic [7:0]                  fc_reg,     fc_next;
    logic [7:0]                  hi_reg,     hi_next;
    logic [15:0]                 tlow_reg,   tlow_next;
    logic [7:0]                  thigh_reg,  thigh_next;
    logic [ifsd_pkg::LINE_W-1:0] line_reg,   line_next;
    logic [ifsd_pkg::TIME_W-1:0] kept_reg,   kept_next;

    // Output register.
    logic                          out_valid_reg, out_valid_next;
    logic                          kind_reg,      kind_next;
    logic [ifsd_pkg::CH_W-1:0]     chan_reg,      chan_next;
    logic [ifsd_pkg::COL_W-1:0]    col_reg,       col_next;
    logic [ifsd_pkg::LINE_W-1:0]   lnum_reg,      lnum_next;
    logic [ifsd_pkg::WORD_W-1:0]   val_reg,       val_next;
    logic [ifsd_pkg::TIME_W-1:0]   ts_reg,        ts_next;

    // The output register is the only storage on the result side. The input
    // side only waits when that register is full and the sink is stalling.
    assign in_stall = out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    // The frame counter byte is used in the same beat that carries it, so the
    // effective counter bypasses the register at that position.
    logic [7:0]                  fc_eff;
    logic [7:0]                  fc_m1;
    logic                        time_frame;
    logic                        sample_frame;
    logic                        eol_frame;
    logic [ifsd_pkg::CH_W-1:0]   chan_idx;
    logic                        is_sample;
    logic                        is_eol;
    logic [ifsd_pkg::TIME_W-1:0] time_sum;

    assign fc_eff       = (32'(where.pos) == ifsd_pkg::COUNTER_POS) ? data_byte : fc_reg;
    assign fc_m1        = fc_eff - 8'd1;
    assign time_frame   = (fc_eff == 8'd0);
    assign sample_frame = (fc_eff != 8'd0) && (32'(fc_eff) < ifsd_pkg::END_COUNTER);
    assign eol_frame    = (32'(fc_eff) == ifsd_pkg::END_COUNTER);
    assign chan_idx     = where.woff[ifsd_pkg::WOFF_W-1:1];

    // A word completes at its odd (low) byte; only channels in range count.
    assign is_sample = where.in_data && where.woff[0] && sample_frame &&
                       (32'(chan_idx) < ifsd_pkg::CHANNELS);
    assign is_eol    = where.last && eol_frame;

    // Timestamp: offset plus the 32-bit raw time word, one 33-bit add.
    assign time_sum = {1'b0, offset_reg} + {1'b0, thigh_reg, data_byte, tlow_reg};

    always_comb
    begin
        fc_next    = fc_reg;
        hi_next    = hi_reg;
        tlow_next  = tlow_reg;
        thigh_next = thigh_reg;
        line_next  = line_reg;
        kept_next  = kept_reg;

        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        chan_next      = chan_reg;
        col_next       = col_reg;
        lnum_next      = lnum_reg;
        val_next       = val_reg;
        ts_next        = ts_reg;

        if (in_take)
        begin
            fc_next = fc_eff;

            if (time_frame)
            begin
                if (32'(where.pos) == ifsd_pkg::TIME_POS0)
                begin
                    tlow_next = {data_byte, 8'd0};
                end
                else if (32'(where.pos) == ifsd_pkg::TIME_POS1)
                begin
                    tlow_next = {tlow_reg[15:8], data_byte};
                end
                else if (32'(where.pos) == ifsd_pkg::TIME_POS2)
                begin
                    thigh_next = data_byte;
                end
                else if (32'(where.pos) == ifsd_pkg::TIME_POS3)
                begin
                    kept_next = time_sum;
                end
            end

            // The high byte of every word is latched, whatever the counter.
            if (where.in_data && !where.woff[0])
            begin
                hi_next = data_byte;
            end

            if (is_sample)
            begin
                out_valid_next = 1'b1;
                kind_next      = ifsd_pkg::KIND_SAMPLE;
                chan_next      = chan_idx;
                col_next       = ifsd_pkg::COL_W'({fc_m1, where.grp});
                lnum_next      = line_reg;
                val_next       = {hi_reg, data_byte};
                ts_next        = '0;
            end
            else if (is_eol)
            begin
                out_valid_next = 1'b1;
                kind_next      = ifsd_pkg::KIND_EOL;
                chan_next      = '0;
                col_next       = '0;
                lnum_next      = line_reg;
                val_next       = '0;
                ts_next        = kept_reg;
                line_next      = line_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= ifsd_pkg::OFFSET_RESET;
            fc_reg        <= '0;
            hi_reg        <= '0;
            tlow_reg      <= '0;
            thigh_reg     <= '0;
            line_reg      <= '0;
            kept_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                offset_reg <= cfg_wr_data;
            end
            fc_reg        <= fc_next;
            hi_reg        <= hi_next;
            tlow_reg      <= tlow_next;
            thigh_reg     <= thigh_next;
            line_reg      <= line_next;
            kept_reg      <= kept_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload needs no reset; it only matters while out_valid is high.
    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        chan_reg <= chan_next;
        col_reg  <= col_next;
        lnum_reg <= lnum_next;
        val_reg  <= val_next;
        ts_reg   <= ts_next;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign channel      = chan_reg;
    assign column       = col_reg;
    assign line_number  = lnum_reg;
    assign sample_value = val_reg;
    assign timestamp    = ts_reg;

endmodule

`default_nettype wire
